>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every rising clock edge out of reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("concurrent assertion failed");

// expression must never be true on a rising clock edge out of reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

>>> rtl/core/mcfd_pkg.sv
// ----------------------------------------------------------------------------
// mcfd_pkg
// Shared codes, types and sizes of the motor command frame decoder
// ----------------------------------------------------------------------------
`default_nettype none

package mcfd_pkg;

    localparam logic [7:0] START_BYTE     = 8'd255;
    localparam logic [7:0] DIR_CCW_CODE   = 8'd1;
    localparam logic [7:0] DIR_CW_CODE    = 8'd2;
    localparam logic [7:0] ESC_FORCE_LOW  = 8'd1;
    localparam logic [7:0] ESC_FORCE_HIGH = 8'd2;
    localparam logic [7:0] ESC_FORCE_BOTH = 8'd3;
    localparam logic [7:0] FORCED_BYTE    = 8'hFF;

    // power of two so the pointers wrap on their own
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [4:0] {
        PHASE_IDLE = 5'b00001,
        PHASE_HIGH = 5'b00010,
        PHASE_LOW  = 5'b00100,
        PHASE_ESC  = 5'b01000,
        PHASE_DONE = 5'b10000
    } phase_t;

    typedef struct packed {
        logic        counter_clockwise;
        logic [15:0] compare_value;
    } frame_t;

    typedef struct packed {
        logic   valid;
        frame_t frame;
    } push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

>>> rtl/core/mcfd_front.sv
// ----------------------------------------------------------------------------
// mcfd_front
// Byte framer: accepts received bytes, tracks the frame phase and pushes
// each completed command frame into the queue
// ----------------------------------------------------------------------------
`default_nettype none

module mcfd_front (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [7:0]             rx_byte,
    input  wire mcfd_pkg::queue_status_t q_status,
    output mcfd_pkg::push_t             push
);

    mcfd_pkg::phase_t phase_reg, phase_next;
    logic             start_seen_reg, start_seen_next;
    logic             direction_ccw_reg, direction_ccw_next;
    logic [7:0]       high_byte_reg, high_byte_next;
    logic [7:0]       low_byte_reg, low_byte_next;
    logic             accept;
    logic             force_high;
    logic             force_low;

    // only an escape byte can need a queue slot
    assign in_ready = !q_status.full || (phase_reg != mcfd_pkg::PHASE_ESC);
    assign accept   = in_valid && in_ready;

    assign force_high = (rx_byte == mcfd_pkg::ESC_FORCE_HIGH) ||
                        (rx_byte == mcfd_pkg::ESC_FORCE_BOTH);
    assign force_low  = (rx_byte == mcfd_pkg::ESC_FORCE_LOW) ||
                        (rx_byte == mcfd_pkg::ESC_FORCE_BOTH);

    always_comb
    begin
        phase_next         = phase_reg;
        start_seen_next    = start_seen_reg;
        direction_ccw_next = direction_ccw_reg;
        high_byte_next     = high_byte_reg;
        low_byte_next      = low_byte_reg;
        push.valid         = 1'b0;
        push.frame.counter_clockwise = direction_ccw_reg;
        push.frame.compare_value     = {high_byte_reg, low_byte_reg};
        if (accept)
        begin
            if (rx_byte == mcfd_pkg::START_BYTE || phase_reg == mcfd_pkg::PHASE_DONE)
            begin
                phase_next      = mcfd_pkg::PHASE_IDLE;
                start_seen_next = 1'b1;
            end
            else if ((rx_byte == mcfd_pkg::DIR_CCW_CODE || rx_byte == mcfd_pkg::DIR_CW_CODE)
                     && phase_reg == mcfd_pkg::PHASE_IDLE && start_seen_reg)
            begin
                start_seen_next    = 1'b0;
                phase_next         = mcfd_pkg::PHASE_HIGH;
                direction_ccw_next = (rx_byte == mcfd_pkg::DIR_CCW_CODE);
            end
            else
            begin
                case (phase_reg)
                    mcfd_pkg::PHASE_HIGH:
                    begin
                        high_byte_next = rx_byte;
                        phase_next     = mcfd_pkg::PHASE_LOW;
                    end
                    mcfd_pkg::PHASE_LOW:
                    begin
                        low_byte_next = rx_byte;
                        phase_next    = mcfd_pkg::PHASE_ESC;
                    end
                    mcfd_pkg::PHASE_ESC:
                    begin
                        high_byte_next = force_high ? mcfd_pkg::FORCED_BYTE : high_byte_reg;
                        low_byte_next  = force_low  ? mcfd_pkg::FORCED_BYTE : low_byte_reg;
                        phase_next     = mcfd_pkg::PHASE_DONE;
                        push.valid     = 1'b1;
                        push.frame.compare_value = {high_byte_next, low_byte_next};
                    end
                    default:
                    begin
                        // waiting for start, or a stray direction byte
                        start_seen_next = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= mcfd_pkg::PHASE_IDLE;
            start_seen_reg    <= 1'b0;
            direction_ccw_reg <= 1'b0;
            high_byte_reg     <= 8'd0;
            low_byte_reg      <= 8'd0;
        end
        else
        begin
            phase_reg         <= phase_next;
            start_seen_reg    <= start_seen_next;
            direction_ccw_reg <= direction_ccw_next;
            high_byte_reg     <= high_byte_next;
            low_byte_reg      <= low_byte_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/mcfd_queue.sv
// ----------------------------------------------------------------------------
// mcfd_queue
// Short frame queue between the framer and the output stage
// ----------------------------------------------------------------------------
`default_nettype none

module mcfd_queue (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire mcfd_pkg::push_t         push,
    input  wire logic                    pop,
    output mcfd_pkg::queue_status_t      q_status,
    output mcfd_pkg::frame_t             head
);

    mcfd_pkg::frame_t                  slot_reg [mcfd_pkg::QUEUE_DEPTH];
    logic [mcfd_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [mcfd_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [mcfd_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic                              do_push;
    logic                              do_pop;

    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == mcfd_pkg::QCNT_W'(mcfd_pkg::QUEUE_DEPTH));
    assign head           = slot_reg[rd_ptr_reg];

    assign do_push = push.valid && !q_status.full;
    assign do_pop  = pop && !q_status.empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push.frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/mcfd_back.sv
// ----------------------------------------------------------------------------
// mcfd_back
// Output stage: takes frames from the queue and holds each result item
// until the sink accepts it
// ----------------------------------------------------------------------------
`default_nettype none

module mcfd_back (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire mcfd_pkg::queue_status_t q_status,
    input  wire mcfd_pkg::frame_t        head,
    output logic                         pop,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic                         counter_clockwise,
    output logic [15:0]                  compare_value
);

    logic             valid_reg, valid_next;
    mcfd_pkg::frame_t frame_reg;

    assign pop = !q_status.empty && (!valid_reg || out_ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            frame_reg <= head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign out_valid         = valid_reg;
    assign counter_clockwise = frame_reg.counter_clockwise;
    assign compare_value     = frame_reg.compare_value;

endmodule

`default_nettype wire

>>> rtl/core/motor_command_frame_decoder.sv
// ----------------------------------------------------------------------------
// motor_command_frame_decoder
// Decodes five-byte motor command frames from a byte stream into a
// direction and a 16-bit PWM compare word
// ----------------------------------------------------------------------------
//   channel  | signals                          | item
//   ---------+----------------------------------+---------------------------
//   input    | in_valid, in_ready, rx_byte      | one received byte
//   output   | out_valid, out_ready, fields     | one decoded command frame
//
// one byte per cycle while in_ready is high; the framer phase is held in a register
// a result passes through the queue and then the output register once its escape byte is accepted
// a two-frame queue and the output register absorb output stalls
// in_ready drops only on an escape byte while the queue is full
// reset clears phase, start mark, data bytes and queue control
// ----------------------------------------------------------------------------
`default_nettype none

module motor_command_frame_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             counter_clockwise,
    output logic [15:0]      compare_value
);

    mcfd_pkg::push_t         push;
    mcfd_pkg::queue_status_t q_status;
    mcfd_pkg::frame_t        head;
    logic                    pop;

    mcfd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .q_status (q_status),
        .push     (push)
    );

    mcfd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .pop      (pop),
        .q_status (q_status),
        .head     (head)
    );

    mcfd_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_status          (q_status),
        .head              (head),
        .pop               (pop),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .counter_clockwise (counter_clockwise),
        .compare_value     (compare_value)
    );

endmodule

`default_nettype wire

>>> rtl/core/mcfd_checker.sv
// ----------------------------------------------------------------------------
// mcfd_checker
// Port-level checks of the motor command frame decoder
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mcfd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic [7:0]  rx_byte,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        counter_clockwise,
    input wire logic [15:0] compare_value
);

    logic        in_accept;
    logic        in_stall;
    logic        out_stall;
    logic [16:0] out_payload;

    assign in_accept   = in_valid && in_ready;
    assign in_stall    = in_valid && !in_ready;
    assign out_stall   = out_valid && !out_ready;
    assign out_payload = {counter_clockwise, compare_value};

    `ASSERT_CLK(a_in_data_holds, clk, rst_n, in_stall |=> (in_valid && $stable(rx_byte)))
    `ASSERT_CLK(a_out_valid_holds, clk, rst_n, out_stall |=> out_valid)
    `ASSERT_CLK(a_out_data_holds, clk, rst_n, out_stall |=> $stable(out_payload))
    `ASSERT_CLK(a_result_follows_byte, clk, rst_n, $rose(out_valid) |-> $past(in_accept, 2))
    `ASSERT_NEVER(a_stall_only_when_backed_up, clk, rst_n, !in_ready && !out_valid)

endmodule

bind motor_command_frame_decoder mcfd_checker u_mcfd_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .rx_byte           (rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .counter_clockwise (counter_clockwise),
    .compare_value     (compare_value)
);

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Byte-stream check of the motor command frame decoder: a driver feeds
// received bytes from a queue, a local decoder predicts the frames that
// each accepted byte completes, and a monitor compares every output item
// with the oldest predicted frame under random stalls on both sides
// ----------------------------------------------------------------------------

module testbench;

    localparam int CYCLE_LIMIT = 200000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        counter_clockwise;
    logic [15:0] compare_value;

    motor_command_frame_decoder dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .rx_byte           (rx_byte),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .counter_clockwise (counter_clockwise),
        .compare_value     (compare_value)
    );

    always #5 clk = ~clk;

    logic [7:0]       tx_bytes[$];
    mcfd_pkg::frame_t frames_due[$];
    int               bytes_queued = 0;
    int               bytes_taken = 0;
    bit               byte_taken = 1'b0;
    int               send_idle_pct = 0;
    int               recv_idle_pct = 0;
    int               mismatches = 0;
    int               cycle_count = 0;

    // local decoder state
    mcfd_pkg::phase_t dec_phase = mcfd_pkg::PHASE_IDLE;
    logic             dec_start_seen = 1'b0;
    logic             dec_ccw = 1'b0;
    logic [7:0]       dec_high = 8'd0;
    logic [7:0]       dec_low = 8'd0;

    task automatic decode_byte(input logic [7:0] b);
        mcfd_pkg::frame_t f;
        if (b == mcfd_pkg::START_BYTE || dec_phase == mcfd_pkg::PHASE_DONE)
        begin
            dec_phase = mcfd_pkg::PHASE_IDLE;
            dec_start_seen = 1'b1;
        end
        else if ((b == mcfd_pkg::DIR_CCW_CODE || b == mcfd_pkg::DIR_CW_CODE)
                 && dec_phase == mcfd_pkg::PHASE_IDLE && dec_start_seen)
        begin
            dec_start_seen = 1'b0;
            dec_phase = mcfd_pkg::PHASE_HIGH;
            dec_ccw = (b == mcfd_pkg::DIR_CCW_CODE);
        end
        else
        begin
            case (dec_phase)
                mcfd_pkg::PHASE_HIGH:
                begin
                    dec_high = b;
                    dec_phase = mcfd_pkg::PHASE_LOW;
                end
                mcfd_pkg::PHASE_LOW:
                begin
                    dec_low = b;
                    dec_phase = mcfd_pkg::PHASE_ESC;
                end
                mcfd_pkg::PHASE_ESC:
                begin
                    if (b == mcfd_pkg::ESC_FORCE_LOW)
                    begin
                        dec_low = mcfd_pkg::FORCED_BYTE;
                    end
                    else if (b == mcfd_pkg::ESC_FORCE_HIGH)
                    begin
                        dec_high = mcfd_pkg::FORCED_BYTE;
                    end
                    else if (b == mcfd_pkg::ESC_FORCE_BOTH)
                    begin
                        dec_high = mcfd_pkg::FORCED_BYTE;
                        dec_low = mcfd_pkg::FORCED_BYTE;
                    end
                    dec_phase = mcfd_pkg::PHASE_DONE;
                    f.counter_clockwise = dec_ccw;
                    f.compare_value = {dec_high, dec_low};
                    frames_due.push_back(f);
                end
                default:
                begin
                    dec_start_seen = 1'b0;
                end
            endcase
        end
    endtask

    task automatic report_mismatch(input string what, input int exp_val, input int act_val);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("mismatch on %s: expected 0x%0h, got 0x%0h", what, exp_val, act_val);
        end
    endtask

    // input side sampling and output checking
    always @(posedge clk)
    begin : sample
        mcfd_pkg::frame_t f;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                decode_byte(rx_byte);
                byte_taken = 1'b1;
                bytes_taken++;
            end
            if (out_valid && out_ready)
            begin
                if (frames_due.size() == 0)
                begin
                    report_mismatch("unexpected frame", 0, {counter_clockwise, compare_value});
                end
                else
                begin
                    f = frames_due.pop_front();
                    if (counter_clockwise !== f.counter_clockwise)
                    begin
                        report_mismatch("counter_clockwise", f.counter_clockwise,
                                        counter_clockwise);
                    end
                    if (compare_value !== f.compare_value)
                    begin
                        report_mismatch("compare_value", f.compare_value, compare_value);
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin : drive
        logic       nv;
        logic [7:0] nb;
        nv = in_valid;
        nb = rx_byte;
        if (byte_taken)
        begin
            nv = 1'b0;
            byte_taken = 1'b0;
        end
        if (rst_n && !nv && tx_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct)
        begin
            nv = 1'b1;
            nb = tx_bytes.pop_front();
        end
        in_valid <= nv;
        rx_byte <= nb;
    end

    always @(negedge clk)
    begin
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic push_byte(input logic [7:0] b);
        tx_bytes.push_back(b);
        bytes_queued++;
    endtask

    task automatic push_frame(input logic [7:0] dir, input logic [7:0] hi,
                              input logic [7:0] lo, input logic [7:0] esc);
        push_byte(mcfd_pkg::START_BYTE);
        push_byte(dir);
        push_byte(hi);
        push_byte(lo);
        push_byte(esc);
    endtask

    function automatic logic [7:0] pick_data();
        int r;
        r = $urandom_range(99);
        if (r < 20)
        begin
            return 8'd0;
        end
        else if (r < 40)
        begin
            return 8'd254;
        end
        return 8'($urandom_range(254));
    endfunction

    task automatic gen_traffic(input int n_items);
        int         stop_at;
        int         r;
        int         k;
        logic [7:0] dir;
        logic [7:0] esc;
        stop_at = bytes_queued + n_items;
        while (bytes_queued < stop_at)
        begin
            r = $urandom_range(99);
            if (r < 70)
            begin
                // well-formed frame, sometimes with the start byte replaced
                if ($urandom_range(99) < 15)
                begin
                    push_byte(8'($urandom_range(254)));
                end
                else
                begin
                    push_byte(mcfd_pkg::START_BYTE);
                end
                dir = ($urandom_range(1) != 0) ? mcfd_pkg::DIR_CCW_CODE
                                               : mcfd_pkg::DIR_CW_CODE;
                esc = ($urandom_range(99) < 80) ? 8'($urandom_range(3))
                                                : 8'($urandom_range(254));
                push_byte(dir);
                push_byte(pick_data());
                push_byte(pick_data());
                push_byte(esc);
            end
            else if (r < 85)
            begin
                // broken frame, sometimes cut off by a fresh start byte
                push_byte(mcfd_pkg::START_BYTE);
                push_byte(8'($urandom_range(255)));
                k = $urandom_range(2);
                repeat (k) push_byte(pick_data());
                if ($urandom_range(1) != 0)
                begin
                    push_byte(mcfd_pkg::START_BYTE);
                end
            end
            else
            begin
                k = $urandom_range(1, 4);
                repeat (k) push_byte(8'($urandom_range(255)));
            end
        end
    endtask

    task automatic wait_drained();
        do
        begin
            @(negedge clk);
        end
        while (bytes_taken != bytes_queued || frames_due.size() != 0);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 10;
        recv_idle_pct = 61;

        // direction bytes without a start mark
        push_byte(mcfd_pkg::DIR_CCW_CODE);
        push_byte(mcfd_pkg::DIR_CW_CODE);
        // extremes of the data bytes, escape other than force, then force low
        push_frame(mcfd_pkg::DIR_CCW_CODE, 8'd0, 8'd0, 8'd0);
        push_frame(mcfd_pkg::DIR_CW_CODE, 8'd254, 8'd254, mcfd_pkg::ESC_FORCE_LOW);
        // byte after a complete frame acts as start
        push_byte(8'd9);
        push_byte(mcfd_pkg::DIR_CCW_CODE);
        push_byte(8'h5A);
        push_byte(8'hA5);
        push_byte(mcfd_pkg::ESC_FORCE_BOTH);
        // bad direction byte clears the start mark
        push_byte(mcfd_pkg::START_BYTE);
        push_byte(8'd7);
        push_byte(mcfd_pkg::DIR_CCW_CODE);
        // start byte in the data and escape positions
        push_byte(mcfd_pkg::START_BYTE);
        push_byte(mcfd_pkg::DIR_CW_CODE);
        push_byte(8'h80);
        push_byte(mcfd_pkg::START_BYTE);
        push_byte(mcfd_pkg::DIR_CCW_CODE);
        push_byte(8'h01);
        push_byte(8'h7F);
        push_byte(mcfd_pkg::START_BYTE);
        push_byte(mcfd_pkg::DIR_CW_CODE);
        push_byte(8'hAA);
        push_byte(8'h55);
        push_byte(mcfd_pkg::ESC_FORCE_HIGH);

        gen_traffic(110);
        wait_drained();

        send_idle_pct = 61;
        recv_idle_pct = 10;
        gen_traffic(135);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        gen_traffic(135);
        wait_drained();

        repeat (20) @(negedge clk);
        if (mismatches == 0 && frames_due.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
